@@ rtl/core/bps_pkg.sv @@
package bps_pkg;

  // Fixed field widths
  localparam int POS_W   = 18;
  localparam int CFG_W   = 10;
  localparam int ADDR9_W = 9;
  localparam int PIX_W   = 8;

  // Default geometry and fraction width
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_FRAC_BITS  = 8;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 10'd400;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 10'd300;

  // Operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

endpackage

@@ rtl/core/bilinear_pixel_sampler.sv @@
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+------------------------------------------
// item in   | input     | start & !busy         | operation, write_row/col/value, sample_row/col
// result    | output    | done (one cycle)      | sample_value, inside_res
// config    | input     | cfg_valid & cfg_ready | cfg_index, cfg_data
//
// One item is taken every cycle; busy stays low and cfg_ready stays high.
// A sample result shows on done after its item passes decode and bank addressing,
// bank read, horizontal blend and vertical blend, in that order.
// The image lives in four banks split by row and column parity, so the four
// neighbors of a sample are read in the same cycle, one from each bank.
// Reset clears the pipeline and loads the register defaults; image content is
// undefined until written. Results cannot be held off by the receiver.
module bilinear_pixel_sampler
  import bps_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    operation,
  input  logic [ADDR9_W-1:0]      write_row,
  input  logic [ADDR9_W-1:0]      write_col,
  input  logic [PIX_W-1:0]        write_value,
  input  logic signed [POS_W-1:0] sample_row,
  input  logic signed [POS_W-1:0] sample_col,
  output logic                    done,
  output logic [PIX_W-1:0]        sample_value,
  output logic                    inside_res,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int HALF_W = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
  localparam int DEPTH  = HALF_W * HALF_H;
  localparam int HR_W   = (HALF_H > 1) ? $clog2(HALF_H) : 1;
  localparam int HC_W   = (HALF_W > 1) ? $clog2(HALF_W) : 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NBANK  = 4;

  // Configuration registers
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Load configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode: floor, fraction, inside check, bank addresses
  logic                    accept;
  logic [POS_W-1:0]        wd_lim;
  logic [POS_W-1:0]        ht_lim;
  logic signed [POS_W-1:0] row_floor;
  logic signed [POS_W-1:0] col_floor;
  logic [POS_W-1:0]        row_u;
  logic [POS_W-1:0]        col_u;
  logic [POS_W-1:0]        row_p1;
  logic [POS_W-1:0]        col_p1;
  logic                    in_range;
  logic [HR_W-1:0]         row_half [2];
  logic [HC_W-1:0]         col_half [2];
  logic [ADDR_W-1:0]       rd_addr [NBANK];
  logic                    wr_legal;
  logic [ADDR_W-1:0]       wr_addr;

  assign accept = start && !busy;

  always_comb begin
    wd_lim = (POS_W'(image_width) > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH)
                                                       : POS_W'(image_width);
    ht_lim = (POS_W'(image_height) > POS_W'(MAX_HEIGHT)) ? POS_W'(MAX_HEIGHT)
                                                         : POS_W'(image_height);
    row_floor = sample_row >>> FRAC_BITS;
    col_floor = sample_col >>> FRAC_BITS;
    row_u     = row_floor;
    col_u     = col_floor;
    row_p1    = row_u + POS_W'(1);
    col_p1    = col_u + POS_W'(1);
    in_range  = !sample_row[POS_W-1] && !sample_col[POS_W-1] &&
                (row_p1 < ht_lim) && (col_p1 < wd_lim);
    // Even-parity bank holds the even one of r and r+1
    row_half[0] = row_p1[HR_W:1];
    row_half[1] = row_u[HR_W:1];
    col_half[0] = col_p1[HC_W:1];
    col_half[1] = col_u[HC_W:1];
    for (int b = 0; b < NBANK; b++) begin
      rd_addr[b] = ADDR_W'(row_half[b/2]) * ADDR_W'(HALF_W) + ADDR_W'(col_half[b%2]);
    end
    wr_legal = (POS_W'(write_row) < POS_W'(MAX_HEIGHT)) &&
               (POS_W'(write_col) < POS_W'(MAX_WIDTH));
    wr_addr  = ADDR_W'(write_row[ADDR9_W-1:1]) * ADDR_W'(HALF_W) +
               ADDR_W'(write_col[ADDR9_W-1:1]);
  end

  // Stage 1: registered item
  logic                 s1_wr_en;
  logic                 s1_rd_en;
  logic                 s1_smp;
  logic [1:0]           s1_wr_bank;
  logic [ADDR_W-1:0]    s1_wr_addr;
  logic [PIX_W-1:0]     s1_wr_data;
  logic [ADDR_W-1:0]    s1_addr [NBANK];
  logic [FRAC_BITS-1:0] s1_fr;
  logic [FRAC_BITS-1:0] s1_fc;
  logic                 s1_r0;
  logic                 s1_c0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_wr_en <= 1'b0;
      s1_rd_en <= 1'b0;
      s1_smp   <= 1'b0;
    end else begin
      s1_wr_en <= accept && (operation == OP_WRITE) && wr_legal;
      s1_rd_en <= accept && (operation == OP_SAMPLE) && in_range;
      s1_smp   <= accept && (operation == OP_SAMPLE);
    end
    s1_wr_bank <= {write_row[0], write_col[0]};
    s1_wr_addr <= wr_addr;
    s1_wr_data <= write_value;
    s1_addr    <= rd_addr;
    s1_fr      <= sample_row[FRAC_BITS-1:0];
    s1_fc      <= sample_col[FRAC_BITS-1:0];
    s1_r0      <= row_u[0];
    s1_c0      <= col_u[0];
  end

  // Stage 2: parity banks, one write or one read per item
  logic [PIX_W-1:0] rd_data [NBANK];

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    logic [PIX_W-1:0] mem [DEPTH];
    always_ff @(posedge clk) begin
      if (s1_wr_en && (s1_wr_bank == 2'(b))) begin
        mem[s1_wr_addr] <= s1_wr_data;
      end
      if (s1_rd_en) begin
        rd_data[b] <= mem[s1_addr[b]];
      end
    end
  end

  logic                 s2_smp;
  logic                 s2_inside;
  logic [FRAC_BITS-1:0] s2_fr;
  logic [FRAC_BITS-1:0] s2_fc;
  logic                 s2_r0;
  logic                 s2_c0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_smp <= 1'b0;
    end else begin
      s2_smp <= s1_smp;
    end
    s2_inside <= s1_rd_en;
    s2_fr     <= s1_fr;
    s2_fc     <= s1_fc;
    s2_r0     <= s1_r0;
    s2_c0     <= s1_c0;
  end

  // Blend lo toward hi by weight w, truncated: lo + floor(w*(hi-lo)/ONE)
  function automatic logic [PIX_W-1:0] lerp(input logic [PIX_W-1:0] lo,
                                            input logic [PIX_W-1:0] hi,
                                            input logic [FRAC_BITS-1:0] w);
    logic signed [PIX_W:0]           d;
    logic signed [FRAC_BITS+PIX_W+1:0] prod;
    logic signed [FRAC_BITS+PIX_W+1:0] sum;
    d    = signed'({1'b0, hi}) - signed'({1'b0, lo});
    prod = d * signed'({1'b0, w});
    sum  = (prod >>> FRAC_BITS) + signed'({{(FRAC_BITS+2){1'b0}}, lo});
    return sum[PIX_W-1:0];
  endfunction

  // Route bank outputs to neighbor positions
  logic [PIX_W-1:0] p00, p01, p10, p11;

  always_comb begin
    p00 = rd_data[{s2_r0, s2_c0}];
    p01 = rd_data[{s2_r0, ~s2_c0}];
    p10 = rd_data[{~s2_r0, s2_c0}];
    p11 = rd_data[{~s2_r0, ~s2_c0}];
  end

  // Stage 3: horizontal blend on both rows
  logic                 s3_smp;
  logic                 s3_inside;
  logic [FRAC_BITS-1:0] s3_fr;
  logic [PIX_W-1:0]     s3_top;
  logic [PIX_W-1:0]     s3_bot;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_smp <= 1'b0;
    end else begin
      s3_smp <= s2_smp;
    end
    s3_inside <= s2_inside;
    s3_fr     <= s2_fr;
    s3_top    <= lerp(p00, p01, s2_fc);
    s3_bot    <= lerp(p10, p11, s2_fc);
  end

  // Stage 4: vertical blend, drop to zero when outside
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_smp;
    end
    sample_value <= s3_inside ? lerp(s3_top, s3_bot, s3_fr) : '0;
    inside_res   <= s3_inside;
  end

endmodule

@@ rtl/core/bps_checker.sv @@
module bps_checker
  import bps_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             operation,
  input logic             done,
  input logic [PIX_W-1:0] sample_value,
  input logic             inside_res
);

  // Every accepted sample item yields a result on done
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_SAMPLE) |-> ##4 done)
    else $error("sample item gave no result");

  // A write item yields no result
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_WRITE) |-> ##4 !done)
    else $error("write item gave a result");

  // No result without a sample item behind it
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && operation == OP_SAMPLE, 4))
    else $error("result without a sample item");

  // Outside samples read as zero
  assert property (@(posedge clk) disable iff (rst)
    (done && !inside_res) |-> (sample_value == '0))
    else $error("outside sample not zero");

endmodule

bind bilinear_pixel_sampler bps_checker u_bps_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .operation    (operation),
  .done         (done),
  .sample_value (sample_value),
  .inside_res   (inside_res)
);
